// ===== design/turret_track_scan_controller_unit_defines.svh =====
// Assertion macros shared by the turret track/scan controller RTL.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef TURRET_TRACK_SCAN_CONTROLLER_UNIT_DEFINES_SVH
`define TURRET_TRACK_SCAN_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TTS_CHECK_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("turret track/scan controller check failed");

// Next-cycle implication, disabled during reset.
`define TTS_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("turret track/scan controller check failed");

`endif

// ===== design/tts_pkg.sv =====
// Shared types and constants for the turret track/scan controller.
// No dependencies; imported by tts_front, tts_back and the top module.
package tts_pkg;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_TRACK = 2'd2,
    CMD_SCAN  = 2'd3
  } tts_cmd_t;

  typedef enum logic [1:0] {
    LED_KEEP     = 2'd0,
    LED_ALIGNED  = 2'd1,
    LED_OVERRIDE = 2'd2
  } tts_led_t;

  typedef enum logic [2:0] {
    REG_ENC_MIN          = 3'd0,
    REG_ENC_MAX          = 3'd1,
    REG_WRAP_SPAN        = 3'd2,
    REG_COUNTS_PER_DEG   = 3'd3,
    REG_PRESENT_MIN_DIST = 3'd4,
    REG_LOST_LIMIT       = 3'd5,
    REG_EDGE_MARGIN      = 3'd6,
    REG_ALIGNED_ANGLE    = 3'd7
  } tts_reg_t;

  // Frame as classified by the front end.
  typedef struct packed {
    logic restart;
    logic freeze;
    logic hard_stop;
    logic active;
    logic present;
    logic dist_nz;
    logic ang_nz;
    logic ang_pos;
    logic aligned;
    logic below_hi_edge;
    logic above_lo_edge;
    logic above_hi_edge;
    logic below_lo_edge;
  } tts_cls_t;

  typedef struct packed {
    tts_cmd_t cmd;
    logic     stop_first;
    tts_led_t led;
  } tts_res_t;

  localparam int ENC_BITS_DEFAULT = 24;
  localparam int MID_DEPTH        = 4;
  localparam int OUT_DEPTH        = 2;

  localparam int RST_ENC_MIN          = 0;
  localparam int RST_ENC_MAX          = 4096;
  localparam int RST_WRAP_SPAN        = 4096;
  localparam int RST_COUNTS_PER_DEG   = 256;
  localparam int RST_PRESENT_MIN_DIST = 3;
  localparam int RST_LOST_LIMIT       = 10;
  localparam int RST_EDGE_MARGIN      = 5;
  localparam int RST_ALIGNED_ANGLE    = 384;

endpackage

// ===== design/tts_fifo.sv =====
// Small flop-based FIFO used for the classified-frame queue and the result queue.
// Depends on the assertion macro header only.
`include "turret_track_scan_controller_unit_defines.svh"

module tts_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr, wr_ptr_next;
  logic [AW-1:0]    rd_ptr, rd_ptr_next;
  logic [NW-1:0]    count, count_next;

  assign full     = (count == NW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  `TTS_CHECK_NOW(a_fifo_bound, 1'b1, count <= NW'(DEPTH))
  `TTS_CHECK_NOW(a_fifo_no_overrun, push, !full || pop)
  `TTS_CHECK_NEXT(a_fifo_drain, pop && !push && count == NW'(1), empty)

endmodule

// ===== design/tts_front.sv =====
// Front end: takes frames, multiplies the angle and edge margin, then wraps the
// track setpoint and classifies the frame. Depends on tts_pkg.
module tts_front #(
  parameter int ENC_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic                       restart,
  input  logic                       freeze,
  input  logic                       hard_stop,
  input  logic                       zero_request,
  input  logic                       climb_request,
  input  logic                       is_auto,
  input  logic signed [ENC_BITS-1:0] enc_position,
  input  logic signed [15:0]         target_angle,
  input  logic [15:0]                target_distance,
  input  logic signed [ENC_BITS-1:0] enc_min,
  input  logic signed [ENC_BITS-1:0] enc_max,
  input  logic [ENC_BITS-2:0]        wrap_span,
  input  logic [15:0]                counts_per_degree,
  input  logic [15:0]                present_min_distance,
  input  logic [7:0]                 edge_margin_degrees,
  input  logic [15:0]                aligned_angle,
  output logic                       cls_valid,
  input  logic                       cls_ready,
  output tts_pkg::tts_cls_t          cls,
  output logic signed [ENC_BITS-1:0] track_sp
);

  import tts_pkg::*;

  localparam int WW = ((ENC_BITS > 17) ? ENC_BITS : 17) + 2;
  localparam int CW = ((ENC_BITS + 8 > 25) ? ENC_BITS + 8 : 25) + 2;

  logic                       accept;
  logic                       s1_valid, s1_valid_next;
  logic                       s1_restart, s1_freeze, s1_hard_stop, s1_active;
  logic signed [ENC_BITS-1:0] s1_cur;
  logic signed [15:0]         s1_ang;
  logic [15:0]                s1_dist;
  logic signed [32:0]         s1_prod;
  logic [23:0]                s1_margin;

  logic signed [32:0]         rnd;
  logic signed [16:0]         off;
  logic signed [WW-1:0]       desired, up, dn, mn, mx, span, wr;
  logic signed [ENC_BITS-1:0] wr_sat;
  logic signed [CW-1:0]       cur8, lim_hi, lim_lo;
  logic signed [16:0]         ang_ext;
  logic [16:0]                ang_mag;
  logic                       present;

  // Stage 1 holds one frame; it stalls only when the queue behind it is full.
  assign full          = s1_valid && !cls_ready;
  assign accept        = push && !full;
  assign s1_valid_next = accept || full;
  assign cls_valid     = s1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_restart   <= restart;
      s1_freeze    <= freeze;
      s1_hard_stop <= hard_stop;
      s1_active    <= (!zero_request && !climb_request) || is_auto;
      s1_cur       <= enc_position;
      s1_ang       <= target_angle;
      s1_dist      <= target_distance;
      s1_prod      <= target_angle * $signed({1'b0, counts_per_degree});
      s1_margin    <= counts_per_degree * edge_margin_degrees;
    end
  end

  // Round the Q16.16 offset to whole counts, halves toward plus infinity.
  assign rnd     = s1_prod + 33'sd32768;
  assign off     = rnd[32:16];
  assign desired = WW'(s1_cur) + WW'(off);
  assign mn      = WW'(enc_min);
  assign mx      = WW'(enc_max);
  assign span    = WW'($signed({1'b0, wrap_span}));
  assign up      = desired + span;
  assign dn      = desired - span;

  always_comb begin
    if (desired < mn) begin
      wr = (up > mx) ? mn : up;
    end else if (desired > mx) begin
      wr = (dn < mn) ? mx : dn;
    end else if (desired == mx || desired == mn) begin
      wr = WW'(s1_cur);
    end else begin
      wr = desired;
    end
  end

  always_comb begin
    if ((&wr[WW-1:ENC_BITS-1]) || !(|wr[WW-1:ENC_BITS-1])) begin
      wr_sat = wr[ENC_BITS-1:0];
    end else if (wr[WW-1]) begin
      wr_sat = {1'b1, {(ENC_BITS-1){1'b0}}};
    end else begin
      wr_sat = {1'b0, {(ENC_BITS-1){1'b1}}};
    end
  end

  assign present  = (s1_dist >= present_min_distance);
  assign track_sp = present ? wr_sat : s1_cur;

  // Edge tests are exact in signed fixed point with 8 fractional bits (Q25.8 at ENC_BITS = 24).
  assign cur8   = CW'(s1_cur) <<< 8;
  assign lim_hi = (CW'(enc_max) <<< 8) - CW'($signed({1'b0, s1_margin}));
  assign lim_lo = (CW'(enc_min) <<< 8) + CW'($signed({1'b0, s1_margin}));

  assign ang_ext = 17'(s1_ang);
  assign ang_mag = ang_ext[16] ? (17'd0 - ang_ext) : ang_ext;

  always_comb begin
    cls.restart       = s1_restart;
    cls.freeze        = s1_freeze;
    cls.hard_stop     = s1_hard_stop;
    cls.active        = s1_active;
    cls.present       = present;
    cls.dist_nz       = (s1_dist != '0);
    cls.ang_nz        = (s1_ang != '0);
    cls.ang_pos       = !s1_ang[15] && (s1_ang != '0);
    cls.aligned       = (ang_mag < {1'b0, aligned_angle});
    cls.below_hi_edge = (cur8 < lim_hi);
    cls.above_lo_edge = (cur8 > lim_lo);
    cls.above_hi_edge = (cur8 > lim_hi);
    cls.below_lo_edge = (cur8 < lim_lo);
  end

endmodule

// ===== design/tts_back.sv =====
// Back end: applies one classified frame to the tracking state and forms the
// turret command. Depends on tts_pkg and the assertion macro header.
`include "turret_track_scan_controller_unit_defines.svh"

module tts_back #(
  parameter int ENC_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       out_ready,
  output logic                       take,
  input  tts_pkg::tts_cls_t          cls,
  input  logic signed [ENC_BITS-1:0] track_sp,
  input  logic signed [ENC_BITS-1:0] enc_min,
  input  logic signed [ENC_BITS-1:0] enc_max,
  input  logic [15:0]                counts_per_degree,
  input  logic [7:0]                 lost_frames_limit,
  output tts_pkg::tts_res_t          res,
  output logic signed [ENC_BITS-1:0] sp
);

  import tts_pkg::*;

  logic [7:0] lost_frames, lost_frames_next;
  logic       last_side_positive, last_side_positive_next;
  logic       sweep_up, sweep_up_next;
  logic       scan_wanted, scan_wanted_next;
  logic       old_target_wanted, old_target_wanted_next;

  logic [8:0]                 deg1;
  logic signed [ENC_BITS:0]   up_raw, dn_raw;
  logic signed [ENC_BITS-1:0] up_sp, dn_sp, sp_raw;
  logic                       stopped, stop_before;
  tts_cmd_t                   cmd;
  tts_led_t                   led;

  assign take = in_valid && out_ready;

  // One degree of counts, rounded halves up.
  assign deg1   = 9'((17'(counts_per_degree) + 17'd128) >> 8);
  assign up_raw = (ENC_BITS+1)'(enc_max) - (ENC_BITS+1)'($signed({1'b0, deg1}));
  assign dn_raw = (ENC_BITS+1)'(enc_min) + (ENC_BITS+1)'($signed({1'b0, deg1}));

  always_comb begin
    if (up_raw[ENC_BITS] == up_raw[ENC_BITS-1]) begin
      up_sp = up_raw[ENC_BITS-1:0];
    end else begin
      up_sp = {1'b1, {(ENC_BITS-1){1'b0}}};
    end
    if (dn_raw[ENC_BITS] == dn_raw[ENC_BITS-1]) begin
      dn_sp = dn_raw[ENC_BITS-1:0];
    end else begin
      dn_sp = {1'b0, {(ENC_BITS-1){1'b1}}};
    end
  end

  always_comb begin
    lost_frames_next        = lost_frames;
    last_side_positive_next = last_side_positive;
    sweep_up_next           = sweep_up;
    scan_wanted_next        = scan_wanted;
    old_target_wanted_next  = old_target_wanted;
    cmd                     = CMD_NONE;
    led                     = LED_KEEP;
    stopped                 = 1'b0;
    stop_before             = 1'b0;
    sp_raw                  = '0;

    if (cls.restart) begin
      lost_frames_next        = '0;
      last_side_positive_next = 1'b1;
      sweep_up_next           = 1'b1;
      scan_wanted_next        = 1'b0;
      old_target_wanted_next  = 1'b0;
      cmd                     = CMD_STOP;
    end else if (cls.freeze) begin
      cmd = CMD_STOP;
    end else if (cls.hard_stop) begin
      cmd = CMD_NONE;
    end else if (cls.active) begin
      if (cls.present) begin
        lost_frames_next = '0;
        scan_wanted_next = 1'b0;
      end else if (lost_frames != 8'hFF) begin
        lost_frames_next = lost_frames + 1'b1;
      end

      if (cls.dist_nz || lost_frames_next == '0) begin
        stopped                = scan_wanted_next || old_target_wanted_next;
        scan_wanted_next       = 1'b0;
        old_target_wanted_next = 1'b0;
        lost_frames_next       = '0;
        stop_before            = stopped;
        cmd                    = CMD_TRACK;
        sp_raw                 = track_sp;
      end else if (!scan_wanted_next) begin
        // Target just lost: swing toward the side it was last seen on.
        old_target_wanted_next = 1'b1;
        if (last_side_positive_next && cls.below_hi_edge) begin
          cmd           = CMD_SCAN;
          sp_raw        = up_sp;
          sweep_up_next = 1'b1;
        end else if (!last_side_positive_next && cls.above_lo_edge) begin
          cmd           = CMD_SCAN;
          sp_raw        = dn_sp;
          sweep_up_next = 1'b0;
        end else begin
          cmd                    = CMD_STOP;
          stopped                = 1'b1;
          scan_wanted_next       = 1'b1;
          old_target_wanted_next = 1'b0;
        end
      end

      // Long loss: sweep between the limits, reversing near either edge.
      if (scan_wanted_next && lost_frames_next > lost_frames_limit) begin
        old_target_wanted_next = 1'b0;
        stop_before            = stopped;
        cmd                    = CMD_SCAN;
        if (cls.above_hi_edge) begin
          sweep_up_next = 1'b0;
          sp_raw        = enc_min;
        end else if (cls.below_lo_edge) begin
          sweep_up_next = 1'b1;
          sp_raw        = enc_max;
        end else begin
          sp_raw = sweep_up_next ? enc_max : enc_min;
        end
      end

      if (cls.dist_nz) begin
        scan_wanted_next = 1'b0;
        if (cls.ang_nz) begin
          last_side_positive_next = cls.ang_pos;
        end
      end

      led = (cls.present && cls.aligned) ? LED_ALIGNED : LED_OVERRIDE;
    end
  end

  always_comb begin
    res.cmd = cmd;
    res.led = led;
    if (cmd == CMD_NONE || cmd == CMD_STOP) begin
      res.stop_first = 1'b0;
      sp             = '0;
    end else begin
      res.stop_first = stop_before;
      sp             = sp_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lost_frames        <= '0;
      last_side_positive <= 1'b1;
      sweep_up           <= 1'b1;
      scan_wanted        <= 1'b0;
      old_target_wanted  <= 1'b0;
    end else if (take) begin
      lost_frames        <= lost_frames_next;
      last_side_positive <= last_side_positive_next;
      sweep_up           <= sweep_up_next;
      scan_wanted        <= scan_wanted_next;
      old_target_wanted  <= old_target_wanted_next;
    end
  end

  `TTS_CHECK_NOW(a_quiet_cmd_no_sp, take && (res.cmd == CMD_NONE || res.cmd == CMD_STOP), !res.stop_first && sp == '0)
  `TTS_CHECK_NEXT(a_restart_clears, take && cls.restart, lost_frames == '0 && sweep_up && last_side_positive && !scan_wanted && !old_target_wanted)
  `TTS_CHECK_NEXT(a_track_clears_loss, take && res.cmd == CMD_TRACK, lost_frames == '0 && !scan_wanted && !old_target_wanted)

endmodule

// ===== design/turret_track_scan_controller_unit.sv =====
// Turret track/scan controller: one vision frame in, one turret command out.
// Uses tts_pkg, tts_front, tts_fifo and tts_back.
//
// Input side behaves like a queue: a frame beat is taken on a clock edge with
// push high and full low. Result side also behaves like a queue: the oldest
// command is on motor_command/stop_first/setpoint/led_action while empty is
// low, and it is consumed on an edge with pop high and empty low.
// Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data; the
// port is always ready, and writes are expected only while no frame is in flight.
//
// Throughput is one frame per clock while the receiver keeps popping. An
// accepted frame moves from the front stage register through the middle queue
// into the result queue. The front stage registers the angle and edge-margin
// products, the classified frame crosses a four-entry queue, and the back end
// updates the tracking state and writes a two-entry result queue per frame.
// When the receiver stops popping, the result queue, the middle queue and the
// front stage fill (seven frames in total) and then full rises; nothing is lost.
// Reset (synchronous, active high) empties both queues, returns every register
// to its documented default and clears the tracking state; no clearing pass.
module turret_track_scan_controller_unit #(
  parameter int ENC_BITS = tts_pkg::ENC_BITS_DEFAULT
) (
  input  logic                                     clk,
  input  logic                                     rst,
  // Frame channel.
  input  logic                                     push,
  output logic                                     full,
  input  logic                                     restart,
  input  logic                                     freeze,
  input  logic                                     hard_stop,
  input  logic                                     zero_request,
  input  logic                                     climb_request,
  input  logic                                     is_auto,
  input  logic signed [ENC_BITS-1:0]               enc_position,
  input  logic signed [15:0]                       target_angle,
  input  logic [15:0]                              target_distance,
  // Result channel.
  output logic                                     empty,
  input  logic                                     pop,
  output tts_pkg::tts_cmd_t                        motor_command,
  output logic                                     stop_first,
  output logic signed [ENC_BITS-1:0]               setpoint,
  output tts_pkg::tts_led_t                        led_action,
  // Register write channel.
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  tts_pkg::tts_reg_t                        cfg_index,
  input  logic [((ENC_BITS > 16) ? ENC_BITS : 16)-1:0] cfg_data
);

  import tts_pkg::*;

  localparam int MID_W = $bits(tts_cls_t) + ENC_BITS;
  localparam int OUT_W = $bits(tts_res_t) + ENC_BITS;

  // Configuration registers.
  logic signed [ENC_BITS-1:0] enc_min;
  logic signed [ENC_BITS-1:0] enc_max;
  logic [ENC_BITS-2:0]        wrap_span;
  logic [15:0]                counts_per_degree;
  logic [15:0]                present_min_distance;
  logic [7:0]                 lost_frames_limit;
  logic [7:0]                 edge_margin_degrees;
  logic [15:0]                aligned_angle;

  // Front to middle queue.
  logic                       cls_valid, mid_full;
  tts_cls_t                   cls_front;
  logic signed [ENC_BITS-1:0] sp_front;

  // Middle queue to back end.
  logic [MID_W-1:0]           mid_q;
  logic                       mid_empty;
  tts_cls_t                   cls_back;
  logic signed [ENC_BITS-1:0] sp_back;

  // Back end to result queue.
  logic                       take, out_full, out_pop, out_ready;
  tts_res_t                   res_back, res_head;
  logic signed [ENC_BITS-1:0] sp_res;
  logic [OUT_W-1:0]           out_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enc_min              <= ENC_BITS'(RST_ENC_MIN);
      enc_max              <= ENC_BITS'(RST_ENC_MAX);
      wrap_span            <= (ENC_BITS-1)'(RST_WRAP_SPAN);
      counts_per_degree    <= 16'(RST_COUNTS_PER_DEG);
      present_min_distance <= 16'(RST_PRESENT_MIN_DIST);
      lost_frames_limit    <= 8'(RST_LOST_LIMIT);
      edge_margin_degrees  <= 8'(RST_EDGE_MARGIN);
      aligned_angle        <= 16'(RST_ALIGNED_ANGLE);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENC_MIN:          enc_min              <= cfg_data[ENC_BITS-1:0];
        REG_ENC_MAX:          enc_max              <= cfg_data[ENC_BITS-1:0];
        REG_WRAP_SPAN:        wrap_span            <= cfg_data[ENC_BITS-2:0];
        REG_COUNTS_PER_DEG:   counts_per_degree    <= cfg_data[15:0];
        REG_PRESENT_MIN_DIST: present_min_distance <= cfg_data[15:0];
        REG_LOST_LIMIT:       lost_frames_limit    <= cfg_data[7:0];
        REG_EDGE_MARGIN:      edge_margin_degrees  <= cfg_data[7:0];
        REG_ALIGNED_ANGLE:    aligned_angle        <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  tts_front #(
    .ENC_BITS(ENC_BITS)
  ) u_front (
    .clk                  (clk),
    .rst                  (rst),
    .push                 (push),
    .full                 (full),
    .restart              (restart),
    .freeze               (freeze),
    .hard_stop            (hard_stop),
    .zero_request         (zero_request),
    .climb_request        (climb_request),
    .is_auto              (is_auto),
    .enc_position         (enc_position),
    .target_angle         (target_angle),
    .target_distance      (target_distance),
    .enc_min              (enc_min),
    .enc_max              (enc_max),
    .wrap_span            (wrap_span),
    .counts_per_degree    (counts_per_degree),
    .present_min_distance (present_min_distance),
    .edge_margin_degrees  (edge_margin_degrees),
    .aligned_angle        (aligned_angle),
    .cls_valid            (cls_valid),
    .cls_ready            (!mid_full),
    .cls                  (cls_front),
    .track_sp             (sp_front)
  );

  // The front end only pushes while the middle queue has room.
  tts_fifo #(
    .WIDTH(MID_W),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk       (clk),
    .rst       (rst),
    .push      (cls_valid && !mid_full),
    .push_data ({cls_front, sp_front}),
    .full      (mid_full),
    .pop       (take),
    .pop_data  (mid_q),
    .empty     (mid_empty)
  );

  assign cls_back = tts_cls_t'(mid_q[MID_W-1:ENC_BITS]);
  assign sp_back  = mid_q[ENC_BITS-1:0];

  // The back end may refill the result queue in the cycle its head is popped.
  assign out_pop   = pop && !empty;
  assign out_ready = !out_full || out_pop;

  tts_back #(
    .ENC_BITS(ENC_BITS)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (!mid_empty),
    .out_ready         (out_ready),
    .take              (take),
    .cls               (cls_back),
    .track_sp          (sp_back),
    .enc_min           (enc_min),
    .enc_max           (enc_max),
    .counts_per_degree (counts_per_degree),
    .lost_frames_limit (lost_frames_limit),
    .res               (res_back),
    .sp                (sp_res)
  );

  tts_fifo #(
    .WIDTH(OUT_W),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data ({res_back, sp_res}),
    .full      (out_full),
    .pop       (out_pop),
    .pop_data  (out_q),
    .empty     (empty)
  );

  assign res_head      = tts_res_t'(out_q[OUT_W-1:ENC_BITS]);
  assign motor_command = res_head.cmd;
  assign stop_first    = res_head.stop_first;
  assign led_action    = res_head.led;
  assign setpoint      = out_q[ENC_BITS-1:0];

endmodule
